>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("next-cycle check failed");

`endif

>>> rtl/olc_pkg.sv
`default_nettype none
package olc_pkg;
	localparam int FEATURES    = 3;
	localparam int SAMPLE_BITS = 16;
	localparam int DIST_W      = 36;
	localparam int RATE_W      = 9;
	localparam int IDX_OUT_W   = 5;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE   = 2'd1;

	localparam logic [DIST_W-1:0] RADIUS_RESET = 36'd4536559;
	localparam logic [RATE_W-1:0] RATE_RESET   = 9'd128;

	typedef struct packed {
		logic                          start_new_set;
		logic signed [SAMPLE_BITS-1:0] feature_0;
		logic signed [SAMPLE_BITS-1:0] feature_1;
		logic signed [SAMPLE_BITS-1:0] feature_2;
	} sample_t;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] cluster_index;
		logic                 created;
		logic                 table_full;
		logic [DIST_W-1:0]    nearest_distance_sq;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic scan;
		logic fetch;
		logic mul;
		logic write_upd;
		logic write_new;
		logic report_full;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic fresh;
		logic scan_last;
		logic pipe_busy;
		logic match;
		logic room;
	} status_t;
endpackage
`default_nettype wire

>>> rtl/olc_ctrl.sv
`default_nettype none
module olc_ctrl import olc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire status_t status,
	output cmd_t         cmd,
	output logic         busy,
	output logic         done
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DRAIN  = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_FETCH  = 3'd4;
	localparam logic [2:0] S_MUL    = 3'd5;
	localparam logic [2:0] S_UPD    = 3'd6;
	localparam logic [2:0] S_NEW    = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       done_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = status.fresh ? S_NEW : S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_last)
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!status.pipe_busy)
					state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (status.match) begin
					state_d = S_FETCH;
				end else if (status.room) begin
					state_d = S_NEW;
				end else begin
					cmd.report_full = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				cmd.write_upd = 1'b1;
				state_d       = S_IDLE;
			end
			S_NEW: begin
				cmd.write_new = 1'b1;
				state_d       = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.write_new | cmd.write_upd | cmd.report_full;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
endmodule
`default_nettype wire

>>> rtl/olc_datapath.sv
`default_nettype none
module olc_datapath import olc_pkg::*; #(
	parameter int MAX_CLUSTERS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire sample_t              sample,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIST_W-1:0]    cfg_data,
	input  wire cmd_t                 cmd,
	output status_t                   status,
	output result_t                   result
);
	localparam int IDX_W   = $clog2(MAX_CLUSTERS);
	localparam int CNT_W   = $clog2(MAX_CLUSTERS + 1);
	localparam int ROW_W   = FEATURES * SAMPLE_BITS;
	localparam int DIFF_W  = SAMPLE_BITS + 1;
	localparam int SQ_W    = 2 * DIFF_W;
	localparam int PROD_W  = DIFF_W + RATE_W + 1;
	localparam int STEP_W  = PROD_W - 8;
	localparam int NEXT_W  = STEP_W + 1;
	localparam logic signed [NEXT_W-1:0] HI_LIM =
		{{(NEXT_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [NEXT_W-1:0] LO_LIM = ~HI_LIM;

	// centroid table, one row holds every feature of a cluster
	logic [ROW_W-1:0] mem_q [MAX_CLUSTERS];

	logic [DIST_W-1:0] radius_q;
	logic [RATE_W-1:0] rate_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  k_q;
	logic              vld_s1;
	logic              vld_s2;
	logic [IDX_W-1:0]  idx_s1;
	logic [IDX_W-1:0]  idx_s2;
	logic [ROW_W-1:0]  rd_s1;
	logic [SQ_W-1:0]   sq_s2 [FEATURES];
	logic [ROW_W-1:0]  x_q;
	logic [IDX_W-1:0]  best_q;
	logic [DIST_W-1:0] best_d_q;
	logic signed [PROD_W-1:0] prod_q [FEATURES];
	result_t           result_q;

	logic [ROW_W-1:0]         row_in;
	logic [IDX_W-1:0]         rd_addr;
	logic signed [DIFF_W-1:0] diff [FEATURES];
	logic signed [SQ_W-1:0]   sq_c [FEATURES];
	logic signed [PROD_W-1:0] prod_c [FEATURES];
	logic [DIST_W-1:0]        dsum;
	logic [ROW_W-1:0]         upd_row;

	assign row_in  = {sample.feature_2, sample.feature_1, sample.feature_0};
	assign rd_addr = cmd.fetch ? best_q : k_q;

	always_comb begin
		logic signed [SAMPLE_BITS-1:0] cv;
		logic signed [SAMPLE_BITS-1:0] xv;
		logic signed [STEP_W-1:0]      step;
		logic signed [NEXT_W-1:0]      nv;
		dsum    = '0;
		upd_row = '0;
		for (int f = 0; f < FEATURES; f++) begin
			cv        = $signed(rd_s1[f*SAMPLE_BITS +: SAMPLE_BITS]);
			xv        = $signed(x_q[f*SAMPLE_BITS +: SAMPLE_BITS]);
			diff[f]   = DIFF_W'(xv) - DIFF_W'(cv);
			sq_c[f]   = diff[f] * diff[f];
			prod_c[f] = $signed({1'b0, rate_q}) * diff[f];
			dsum      = dsum + DIST_W'(sq_s2[f]);
			// floor division by 256
			step      = $signed(prod_q[f][PROD_W-1:8]);
			nv        = NEXT_W'(cv) + NEXT_W'(step);
			if (nv > HI_LIM)
				upd_row[f*SAMPLE_BITS +: SAMPLE_BITS] = HI_LIM[SAMPLE_BITS-1:0];
			else if (nv < LO_LIM)
				upd_row[f*SAMPLE_BITS +: SAMPLE_BITS] = LO_LIM[SAMPLE_BITS-1:0];
			else
				upd_row[f*SAMPLE_BITS +: SAMPLE_BITS] = nv[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
			rate_q   <= RATE_RESET;
			count_q  <= '0;
			k_q      <= '0;
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_RADIUS: radius_q <= cfg_data;
					REG_RATE:   rate_q   <= cfg_data[RATE_W-1:0];
					default:    ;
				endcase
			end
			if (cmd.accept) begin
				k_q <= '0;
				if (sample.start_new_set)
					count_q <= '0;
			end else if (cmd.scan) begin
				k_q <= k_q + IDX_W'(1);
			end
			if (cmd.write_new)
				count_q <= count_q + CNT_W'(1);
			vld_s1 <= cmd.scan;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_new)
			mem_q[count_q[IDX_W-1:0]] <= x_q;
		else if (cmd.write_upd)
			mem_q[best_q] <= upd_row;
		if (cmd.scan || cmd.fetch)
			rd_s1 <= mem_q[rd_addr];
		idx_s1 <= k_q;
		idx_s2 <= idx_s1;
		for (int f = 0; f < FEATURES; f++) begin
			sq_s2[f] <= SQ_W'(sq_c[f]);
			if (cmd.mul)
				prod_q[f] <= prod_c[f];
		end
		if (cmd.accept) begin
			x_q      <= row_in;
			best_q   <= '0;
			best_d_q <= '0;
		end else if (vld_s2 && (idx_s2 == '0 || dsum <= best_d_q)) begin
			// later index wins a tie
			best_q   <= idx_s2;
			best_d_q <= dsum;
		end
		if (cmd.write_new) begin
			result_q.cluster_index       <= IDX_OUT_W'(count_q);
			result_q.created             <= 1'b1;
			result_q.table_full          <= 1'b0;
			result_q.nearest_distance_sq <= best_d_q;
		end else if (cmd.write_upd || cmd.report_full) begin
			result_q.cluster_index       <= IDX_OUT_W'(best_q);
			result_q.created             <= 1'b0;
			result_q.table_full          <= cmd.report_full;
			result_q.nearest_distance_sq <= best_d_q;
		end
	end

	assign status.fresh     = sample.start_new_set || (count_q == '0);
	assign status.scan_last = ((CNT_W'(k_q) + CNT_W'(1)) == count_q);
	assign status.pipe_busy = vld_s1 | vld_s2;
	assign status.match     = (best_d_q <= radius_q);
	assign status.room      = (count_q < CNT_W'(MAX_CLUSTERS));
	assign result           = result_q;
endmodule
`default_nettype wire

>>> rtl/online_leader_clustering.sv
// the n stored clusters are scanned and the pipeline drained, then the nearest one is
// updated on a match, a cluster founded if there is room, else full is reported; a fresh
// set or an empty table founds a cluster at once. A sample is accepted only in idle; the
// single-port table is scanned one row per cycle through a three-stage distance pipeline
// reset: cluster count cleared, radius and rate to their defaults, centroid rows undefined
// the result is shown for one cycle on done and cannot be stalled
`default_nettype none
module online_leader_clustering import olc_pkg::*; #(
	parameter int MAX_CLUSTERS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire sample_t              sample,
	output logic                      busy,
	output logic                      done,
	output result_t                   result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIST_W-1:0]    cfg_data
);
	cmd_t    cmd;
	status_t status;

	olc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	olc_datapath #(
		.MAX_CLUSTERS (MAX_CLUSTERS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);
endmodule
`default_nettype wire

>>> rtl/olc_checker.sv
`default_nettype none
`include "assert_macros.svh"
module olc_checker import olc_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    start,
	input wire logic    busy,
	input wire logic    done,
	input wire result_t result
);
	// a result transfer only happens once the block is free again
	`ASSERT_IMPLIES(a_done_idle, clk, arst_n, done, !busy)
	// an accepted sample always keeps the block busy next cycle
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`ASSERT_IMPLIES(a_busy_from_start, clk, arst_n, $rose(busy), $past(start))
	// every busy period ends with exactly its result
	`ASSERT_IMPLIES(a_fall_done, clk, arst_n, $fell(busy), done)
	`ASSERT_IMPLIES(a_full_no_new, clk, arst_n, done, !(result.created && result.table_full))
endmodule

bind online_leader_clustering olc_checker u_olc_checker (.*);
`default_nettype wire
